// ===== sv/minv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_pkg - shared types and constants for the modular inverse core
// Status codes, the default operand width and the control and status
// bundles passed between the sequencer and the shared divide unit.
// ----------------------------------------------------------------------------
package minv_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH       = 32;
    localparam int STATUS_WIDTH      = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK          = 2'd0,
        ST_NOT_COPRIME = 2'd1,
        ST_ZERO_MOD    = 2'd2
    } status_t;

    // Sequencer to divide unit
    typedef struct packed {
        logic start;
        logic mac_en;
    } div_ctrl_t;

    // Divide unit to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/minv_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_divider - shared radix-2 divide and multiply-accumulate unit
// Restoring division, one quotient bit per cycle. Each quotient bit is
// folded into a Horner accumulator so that quotient * coef is ready at
// the same time as the remainder.
// ----------------------------------------------------------------------------
module minv_divider #(
    parameter int OpW = minv_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  minv_pkg::div_ctrl_t ctrl,
    input  logic [OpW-1:0]      dividend,
    input  logic [OpW-1:0]      divisor,
    input  logic [OpW-1:0]      coef,
    output minv_pkg::div_stat_t stat,
    output logic [OpW-1:0]      remainder,
    output logic [OpW-1:0]      product
);
    import minv_pkg::*;

    localparam int CntW = $clog2(OpW + 1);

    logic [OpW-1:0]  rem_reg, rem_next;
    logic [OpW-1:0]  dvd_reg, dvd_next;
    logic [OpW-1:0]  dvs_reg;
    logic [OpW-1:0]  coef_reg;
    logic [OpW-1:0]  acc_reg, acc_next;
    logic            mac_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [OpW:0]    trial;
    logic [OpW:0]    diff;
    logic            ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[OpW-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[OpW-1:0] : trial[OpW-1:0];
        dvd_next = {dvd_reg[OpW-2:0], ge};
        acc_next = {acc_reg[OpW-2:0], 1'b0} + ((ge && mac_reg) ? coef_reg : '0);
        cnt_next = cnt_reg - 1'b1;
        busy_next = busy_reg && (cnt_reg != CntW'(1));
        done_next = busy_reg && (cnt_reg == CntW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CntW'(OpW);
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (busy_reg)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg  <= '0;
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            coef_reg <= coef;
            acc_reg  <= '0;
            mac_reg  <= ctrl.mac_en;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;
    assign product   = acc_reg;

endmodule

// ===== sv/modular_inverse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_core - modular inverse by the extended Euclidean algorithm
// Returns value^-1 mod modulus with a status code, one item at a time.
// ----------------------------------------------------------------------------
// Usage: drive value and modulus with start high while busy is low; the
// item is taken at that clock edge; busy rises for a nonzero modulus.
// One result comes back per item, shown on inverse and status for a
// single cycle while done is high. The receiver cannot stall it, so
// capture it in that cycle. A new item may be started in the cycle
// that done is high.
// Sequencing: every quotient step runs through one shared radix-2
// divider that also forms quotient * coefficient, then through the
// divider's done and the check state. An item costs one reduction
// division (value mod modulus), then one division per Euclid step,
// then the finish state normalises the result and a register presents
// it. With 32-bit operands Euclid needs at most 45 steps; a zero
// modulus raises done in the cycle right after the item is taken.
// Status: ST_OK with the inverse in 0 .. modulus-1, ST_NOT_COPRIME when
// the gcd is not one, ST_ZERO_MOD for a zero modulus (inverse is 0 for
// both errors). A modulus of one gives inverse 0 with ST_OK.
// ----------------------------------------------------------------------------
module modular_inverse_core #(
    parameter int OPERAND_WIDTH = minv_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [minv_pkg::FIELD_WIDTH-1:0]      value,
    input  logic [minv_pkg::FIELD_WIDTH-1:0]      modulus,
    output logic                                  done,
    output logic [minv_pkg::FIELD_WIDTH-1:0]      inverse,
    output logic [minv_pkg::STATUS_WIDTH-1:0]     status
);
    import minv_pkg::*;

    localparam int OpW = OPERAND_WIDTH;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_CHECK  = 5'b00100,
        S_STEP   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Euclid working set: remainders, coefficient magnitudes and signs
    logic [OpW-1:0] m_reg;
    logic [OpW-1:0] r0_reg, r1_reg;
    logic [OpW-1:0] c0_reg, c1_reg;
    logic           n0_reg, n1_reg;

    logic                    done_reg;
    logic [FIELD_WIDTH-1:0]  inv_reg;
    status_t                 status_reg;

    logic [OpW-1:0] a_in, m_in;
    logic [OpW-1:0] c_sum;
    logic [OpW-1:0] c_red;
    logic [OpW-1:0] inv_fin;

    div_ctrl_t      div_ctrl;
    div_stat_t      div_stat;
    logic [OpW-1:0] div_dividend, div_divisor, div_coef;
    logic [OpW-1:0] div_rem, div_prod;

    logic accept;

    // Operands are taken modulo 2^OPERAND_WIDTH
    assign a_in   = OpW'(value);
    assign m_in   = OpW'(modulus);
    assign accept = start && (state_reg == S_IDLE);

    // Next coefficient: c2 = c0 + q * c1 (product from the divide unit)
    assign c_sum = c0_reg + div_prod;

    // Normalise: magnitude never exceeds m, then apply the sign
    always_comb
    begin
        c_red   = (c0_reg == m_reg) ? '0 : c0_reg;
        inv_fin = (n0_reg && (c_red != '0)) ? (m_reg - c_red) : c_red;
    end

    // Feed the shared unit: the reduction divides value by modulus,
    // each Euclid step divides r0 by r1 and accumulates q * c1.
    always_comb
    begin
        div_ctrl.start  = 1'b0;
        div_ctrl.mac_en = 1'b0;
        div_dividend    = r0_reg;
        div_divisor     = r1_reg;
        div_coef        = c1_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                div_dividend = a_in;
                div_divisor  = m_in;
                div_coef     = '0;
                div_ctrl.start = accept && (m_in != '0);
            end
            S_CHECK:
            begin
                div_ctrl.start  = (r1_reg != '0);
                div_ctrl.mac_en = 1'b1;
            end
            S_REDUCE, S_STEP, S_FINISH:
            begin
                div_ctrl.start = 1'b0;
            end
            default:
            begin
                div_ctrl.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (m_in != '0))
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE, S_STEP:
            begin
                if (div_stat.done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (r1_reg != '0) ? S_STEP : S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Strobe for one cycle: zero modulus at once, others at the end
            done_reg  <= (accept && (m_in == '0)) || (state_reg == S_FINISH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_reg <= m_in;
            if (m_in == '0)
            begin
                inv_reg    <= '0;
                status_reg <= ST_ZERO_MOD;
            end
        end
        if ((state_reg == S_REDUCE) && div_stat.done)
        begin
            // Start Euclid on (m, a mod m) with coefficients 0 and 1
            r0_reg <= m_reg;
            r1_reg <= div_rem;
            c0_reg <= '0;
            c1_reg <= OpW'(1);
            n0_reg <= 1'b0;
            n1_reg <= 1'b0;
        end
        if ((state_reg == S_STEP) && div_stat.done)
        begin
            // Advance one quotient step; the coefficient sign alternates
            r0_reg <= r1_reg;
            r1_reg <= div_rem;
            c0_reg <= c1_reg;
            c1_reg <= c_sum;
            n0_reg <= n1_reg;
            n1_reg <= ~n1_reg;
        end
        if (state_reg == S_FINISH)
        begin
            if (r0_reg != OpW'(1))
            begin
                inv_reg    <= '0;
                status_reg <= ST_NOT_COPRIME;
            end
            else
            begin
                inv_reg    <= FIELD_WIDTH'(inv_fin);
                status_reg <= ST_OK;
            end
        end
    end

    minv_divider #(
        .OpW(OpW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .coef      (div_coef),
        .stat      (div_stat),
        .remainder (div_rem),
        .product   (div_prod)
    );

    assign busy    = (state_reg != S_IDLE) || div_stat.busy;
    assign done    = done_reg;
    assign inverse = inv_reg;
    assign status  = status_reg;

endmodule

// ===== test/modular_inverse_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_core_tb - self-checking bench for the modular inverse core
// Feeds value/modulus items through the start/busy handshake in random
// bursts, predicts each inverse and status with an independent extended
// Euclid, and checks every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module modular_inverse_core_tb;

    import minv_pkg::*;

    localparam int W = FIELD_WIDTH;

    // Slowest legal run: 312 items, each with its busy time plus a sender gap.
    // Allow three times that before declaring the core hung.
    localparam int CYCLE_LIMIT = 3_000_000;

    // Cycles to keep watching the result port once the last result is in
    localparam int TAIL_CYCLES = 40;

    localparam int N_RANDOM = 290;

    typedef struct {
        logic [W-1:0] value;
        logic [W-1:0] modulus;
        bit           wait_idle;   // hold this item back until all results are in
    } mi_item_t;

    typedef struct {
        logic [W-1:0] inverse;
        status_t      status;
    } inv_result_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------------
    logic         clk     = 1'b0;
    logic         rst_n   = 1'b0;
    logic         start   = 1'b0;
    logic [W-1:0] value   = '0;
    logic [W-1:0] modulus = '0;
    logic         busy;
    logic         done;
    logic [W-1:0] inverse;
    logic [STATUS_WIDTH-1:0] status;

    modular_inverse_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .value   (value),
        .modulus (modulus),
        .done    (done),
        .inverse (inverse),
        .status  (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    mi_item_t    pending_q[$];     // items still to be offered to the core
    inv_result_t inverse_q[$];     // predicted results awaiting a done strobe

    int unsigned n_accepted = 0;   // written by the driver only (nonblocking)
    int unsigned n_checked  = 0;   // written by the monitor only (nonblocking)
    int unsigned n_errors   = 0;
    int unsigned n_ok       = 0;
    int unsigned n_coprime  = 0;
    int unsigned n_zero_mod = 0;
    int unsigned n_idle_waits = 0;
    int unsigned cycle_count  = 0;

    // ------------------------------------------------------------------------
    // Prediction: extended Euclid on (modulus, value mod modulus). Only the
    // magnitudes of the coefficients are kept, with their alternating sign
    // tracked separately; no magnitude ever exceeds the modulus, so the
    // arithmetic stays within the operand width.
    // ------------------------------------------------------------------------
    function automatic inv_result_t predict_inverse(input logic [W-1:0] a,
                                                    input logic [W-1:0] m);
        logic [W-1:0] rem_prev, rem_cur, rem_next;
        logic [W-1:0] coef_prev, coef_cur, coef_next, quot;
        logic         neg_prev, neg_cur;
        inv_result_t  res;
        res.inverse = '0;
        res.status  = ST_OK;
        if (m == '0)
        begin
            res.status = ST_ZERO_MOD;
        end
        else
        begin
            rem_prev  = m;
            rem_cur   = a % m;
            coef_prev = '0;
            coef_cur  = 1;
            neg_prev  = 1'b0;
            neg_cur   = 1'b0;
            while (rem_cur != '0)
            begin
                quot      = rem_prev / rem_cur;
                rem_next  = rem_prev - quot * rem_cur;
                coef_next = coef_prev + quot * coef_cur;
                rem_prev  = rem_cur;
                rem_cur   = rem_next;
                coef_prev = coef_cur;
                neg_prev  = neg_cur;
                coef_cur  = coef_next;
                neg_cur   = !neg_cur;
            end
            if (rem_prev != 1)
            begin
                res.status = ST_NOT_COPRIME;
            end
            else
            begin
                coef_prev = coef_prev % m;
                if (neg_prev && coef_prev != '0)
                    coef_prev = m - coef_prev;
                res.inverse = coef_prev;
            end
        end
        return res;
    endfunction

    task automatic queue_item(input logic [W-1:0] v, input logic [W-1:0] m,
                              input bit wait_idle = 1'b0);
        mi_item_t it;
        it.value     = v;
        it.modulus   = m;
        it.wait_idle = wait_idle;
        pending_q.push_back(it);
    endtask

    // Random item: mostly full-width operands, with a share of small moduli,
    // shared factors, exact multiples and the zero and one moduli.
    task automatic queue_random_item(input bit wait_idle);
        logic [W-1:0] v, m;
        logic [W-1:0] g;
        int unsigned  pick;
        pick = $urandom_range(99);
        v    = $urandom;
        m    = $urandom;
        if (pick < 5)
        begin
            m = '0;
        end
        else if (pick < 10)
        begin
            m = 1;
        end
        else if (pick < 25)
        begin
            m = $urandom_range(2, 16);
        end
        else if (pick < 37)
        begin
            // common factor: gcd is at least g, so no inverse
            g = $urandom_range(2, 65535);
            v = g * $urandom_range(0, 65535);
            m = g * $urandom_range(1, 65535);
        end
        else if (pick < 42)
        begin
            // value an exact multiple of a small modulus
            m = $urandom_range(2, 60000);
            v = m * $urandom_range(0, 65535);
        end
        else if (pick < 50)
        begin
            // value below the modulus, both wide
            m = $urandom | 32'h8000_0000;
            v = $urandom_range(0, 32'h7fff_ffff);
        end
        queue_item(v, m, wait_idle);
    endtask

    // Gap between bursts: either short or long enough to land anywhere
    // in the core's work on the previous item.
    function automatic int unsigned pick_gap();
        if ($urandom_range(1) == 0)
            return $urandom_range(1, 10);
        return $urandom_range(20, 1500);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer queued items in bursts. An item is taken at an edge where
    // start is high and busy is low; hold start and the operands until then.
    // start gets exactly one nonblocking assignment per edge out of reset.
    // ------------------------------------------------------------------------
    mi_item_t    drv_item;
    bit          drv_offering = 1'b0;
    bit          drv_taken;
    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            drv_taken = start && !busy;
            if (drv_taken)
            begin
                inverse_q.push_back(predict_inverse(value, modulus));
                n_accepted   <= n_accepted + 1;
                drv_offering = 1'b0;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = pick_gap();
                end
            end
            if (!drv_offering)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_q.size() != 0 &&
                         (!pending_q[0].wait_idle ||
                          n_accepted + (drv_taken ? 1 : 0) == n_checked))
                begin
                    // an item flagged wait_idle only goes once the core has
                    // returned everything outstanding
                    drv_item = pending_q.pop_front();
                    if (drv_item.wait_idle)
                        n_idle_waits++;
                    value        <= drv_item.value;
                    modulus      <= drv_item.modulus;
                    drv_offering = 1'b1;
                end
            end
            start <= drv_offering;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: a result is valid for the single cycle that done is high;
    // take it at the edge that ends that cycle and check it field by field.
    // ------------------------------------------------------------------------
    inv_result_t mon_expected;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (inverse_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: result with nothing expected: inverse %h status %0d",
                         $time, inverse, status);
            end
            else
            begin
                mon_expected = inverse_q.pop_front();
                n_checked   <= n_checked + 1;
                if (inverse !== mon_expected.inverse)
                begin
                    n_errors++;
                    $display("%0t: inverse mismatch: expected %h actual %h",
                             $time, mon_expected.inverse, inverse);
                end
                if (status !== mon_expected.status)
                begin
                    n_errors++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, mon_expected.status, status);
                end
                case (mon_expected.status)
                    ST_OK:          n_ok++;
                    ST_NOT_COPRIME: n_coprime++;
                    default:        n_zero_mod++;
                endcase
            end
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, inverse_q.size());
            $display("FAIL modular_inverse_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        // Directed: zero and one moduli, operand extremes, values above the
        // modulus, non-coprime pairs and the longest Euclid chain.
        queue_item(32'h0000_0000, 32'h0000_0000);
        queue_item(32'hffff_ffff, 32'h0000_0000);
        queue_item(32'h0000_0000, 32'h0000_0001);
        queue_item(32'hffff_ffff, 32'h0000_0001);
        queue_item(32'h0000_0000, 32'h0000_0007);
        queue_item(32'h0000_000e, 32'h0000_0007);
        queue_item(32'h0000_0003, 32'h0000_0007);
        queue_item(32'h0000_000a, 32'h0000_0007);
        queue_item(32'h0000_0001, 32'h0000_0002);
        queue_item(32'h0000_0000, 32'h0000_0002);
        queue_item(32'hffff_ffff, 32'hffff_ffff);
        queue_item(32'hffff_fffe, 32'hffff_ffff);
        queue_item(32'h0000_0002, 32'hffff_ffff);
        queue_item(32'hffff_ffff, 32'hffff_fffe);
        // consecutive Fibonacci numbers give the most quotient steps
        queue_item(32'd1836311903, 32'd2971215073, 1'b1);
        queue_item(32'd2971215073, 32'd1836311903);
        queue_item(32'h7fff_ffff, 32'h8000_0000);
        queue_item(32'h0000_0001, 32'h8000_0000);
        queue_item(32'hffff_fffe, 32'h8000_0000);
        queue_item(32'd123456789, 32'd4294967291);
        queue_item(32'haaaa_aaaa, 32'h5555_5555);
        queue_item(32'h5555_5555, 32'haaaa_aaab);

        // Random items, now and then waiting for the core to drain
        for (int i = 0; i < N_RANDOM; i++)
            queue_random_item(i % 53 == 26);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to be taken, then for every result to return
        while (pending_q.size() != 0 || start)
            @(negedge clk);
        while (n_accepted != n_checked)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Checked %0d results: %0d inverses, %0d not coprime, %0d zero modulus",
                 n_checked, n_ok, n_coprime, n_zero_mod);
        $display("Sender paused for an idle core %0d times; %0d mismatches",
                 n_idle_waits, n_errors);
        if (n_errors == 0 && inverse_q.size() == 0)
        begin
            $display("PASS modular_inverse_core");
        end
        else
        begin
            $display("FAIL modular_inverse_core");
        end
        $finish;
    end

endmodule

// ===== modular_inverse_core.f =====
sv/minv_pkg.sv
sv/minv_divider.sv
sv/modular_inverse_core.sv
test/modular_inverse_core_tb.sv
